// ===== src/pcma_pkg.sv =====
`default_nettype none

package pcma_pkg;

  localparam int ADC_W      = 12;
  localparam int SMP_AC_W   = 13;   // offset-corrected phase A / C current
  localparam int SMP_B_W    = 14;   // derived phase B current
  localparam int AVG_AC_W   = 17;
  localparam int AVG_B_W    = 18;
  localparam int FRAC_W     = 4;
  localparam int RND_SH     = FRAC_W + 1;  // sum * 2^FRAC * 2 for the rounding term
  localparam int WINDOW_DEF = 15;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  localparam logic [ADC_W-1:0] ZERO_POINT_RST = 12'd2055;

  // per-beat strobes shared by the three lanes
  typedef struct packed {
    logic acc;   // input beat taken, window write and sum update
    logic ld2;   // sum -> rounding numerator
    logic ld3;   // numerator -> reciprocal product
  } pcma_ctl_t;

endpackage

`default_nettype wire

// ===== src/pcma_lane.sv =====
`default_nettype none

module pcma_lane #(
  parameter int WINDOW = pcma_pkg::WINDOW_DEF,
  parameter int SMP_W  = pcma_pkg::SMP_AC_W,
  parameter int AVG_W  = pcma_pkg::AVG_AC_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcma_pkg::pcma_ctl_t         ctl,
  input  logic [$clog2(WINDOW)-1:0]   pos,
  input  logic [$clog2(WINDOW)-1:0]   pos_inc,
  input  logic signed [SMP_W-1:0]     smp,
  output logic signed [AVG_W-1:0]     avg
);
  import pcma_pkg::*;

  localparam int POS_W  = $clog2(WINDOW);
  localparam int SUM_W  = SMP_W + $clog2(WINDOW);
  localparam int NUM_W  = SUM_W + RND_SH;
  localparam int DIV    = 2 * WINDOW;
  localparam int LOG_D  = $clog2(DIV);
  localparam int SHIFT  = NUM_W + LOG_D;
  // ceil(2^SHIFT / DIV): floor(num * MULT >> SHIFT) == num / DIV for num < 2^NUM_W
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + DIV - 1) / DIV;
  localparam int MULT_W = $clog2(MULT + 1);
  localparam int PROD_W = NUM_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT_C = MULT[MULT_W-1:0];

  // window storage; entries not yet written read as zero via vld_r
  logic [SMP_W-1:0]        mem [WINDOW];
  logic [SMP_W-1:0]        rd_r;
  logic [POS_W-1:0]        rd_addr;
  logic [WINDOW-1:0]       vld_r;
  logic signed [SMP_W-1:0] old;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0]        mag;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic                    neg2_r, neg3_r;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [PROD_W-1:0]       quo;
  logic [AVG_W-1:0]        q_mag;

  // read one beat ahead: the slot the next beat will replace
  assign rd_addr = ctl.acc ? pos_inc : pos;
  assign old     = vld_r[pos] ? signed'(rd_r) : '0;
  assign sum_nxt = sum_r + SUM_W'(smp) - SUM_W'(old);

  assign mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign num_nxt  = NUM_W'({mag[SUM_W-2:0], {RND_SH{1'b0}}}) + NUM_W'(WINDOW);
  assign prod_nxt = num_r * MULT_C;

  assign quo   = prod_r >> SHIFT;
  assign q_mag = quo[AVG_W-1:0];
  assign avg   = neg3_r ? -signed'(q_mag) : signed'(q_mag);

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      mem[pos] <= smp;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      sum_r <= '0;
    end else if (ctl.acc) begin
      vld_r[pos] <= 1'b1;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      num_r  <= num_nxt;
      neg2_r <= sum_r[SUM_W-1];
    end
    if (ctl.ld3) begin
      prod_r <= prod_nxt;
      neg3_r <= neg2_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/pcma_merge.sv =====
`default_nettype none

module pcma_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  output logic                                   rdy,
  input  logic signed [pcma_pkg::AVG_AC_W-1:0]   avg_a,
  input  logic signed [pcma_pkg::AVG_B_W-1:0]    avg_b,
  input  logic signed [pcma_pkg::AVG_AC_W-1:0]   avg_c,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [pcma_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import pcma_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - 2 * AVG_AC_W - AVG_B_W;

  logic                   vld_r;
  logic [OUT_TDATA_W-1:0] data_r;
  logic                   ld;

  assign rdy = !vld_r || out_tready;
  assign ld  = in_vld && rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_r <= {{PAD_W{1'b0}}, avg_c, avg_b, avg_a};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

// ===== src/phase_current_moving_average.sv =====
`default_nettype none

// Three-phase current moving average. Each input beat carries the phase A
// and phase C converter codes; the configured zero point is removed, phase B
// is formed as -(A + C), and each current goes into its own window of WINDOW
// entries with a running sum. Each output beat gives the three window means
// in signed fixed point with 4 fraction bits, rounded to nearest, ties away
// from zero. One beat is taken per clock while in_tready is high. The sum
// updates on the edge that takes the input beat; the rounding term, the
// reciprocal multiply and the output register follow in that order. A stall
// on out_tready holds the pipeline and drops in_tready only once all stages
// are full. Windows start as all zeros after reset through per-entry
// valid bits, so there is no clearing pass and the first averages include
// zeros. The user must write zero_point through cfg_wr_en / cfg_wr_data
// only while no beat is in flight; the block itself does not enforce this.
module phase_current_moving_average #(
  parameter int WINDOW = pcma_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [pcma_pkg::ADC_W-1:0]         cfg_wr_data,   // zero_point
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [11:0] phase_a_sample, [23:12] phase_c_sample
  input  logic [pcma_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [16:0] avg_a, [34:17] avg_b, [51:35] avg_c, [55:52] zero
  output logic [pcma_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import pcma_pkg::*;

  localparam int POS_W = $clog2(WINDOW);

  logic [ADC_W-1:0]           zp_r;
  logic [ADC_W-1:0]           phase_a_sample, phase_c_sample;
  logic signed [SMP_AC_W-1:0] cur_a, cur_c;
  logic signed [SMP_B_W-1:0]  cur_b;

  logic [POS_W-1:0] pos_r, pos_inc;
  logic             v1_r, v2_r, v3_r;
  logic             rdy1, rdy2, rdy3, rdy4;
  pcma_ctl_t        ctl;

  logic signed [AVG_AC_W-1:0] avg_a, avg_c;
  logic signed [AVG_B_W-1:0]  avg_b;

  assign phase_a_sample = in_tdata[ADC_W-1:0];
  assign phase_c_sample = in_tdata[2*ADC_W-1:ADC_W];

  assign cur_a = signed'({1'b0, phase_a_sample}) - signed'({1'b0, zp_r});
  assign cur_c = signed'({1'b0, phase_c_sample}) - signed'({1'b0, zp_r});
  assign cur_b = -(SMP_B_W'(cur_a) + SMP_B_W'(cur_c));

  assign pos_inc = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;

  // a stage loads when it is empty or its content moves on this cycle
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign ctl.acc = in_tvalid && in_tready;
  assign ctl.ld2 = v1_r && rdy2;
  assign ctl.ld3 = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_r  <= ZERO_POINT_RST;
      pos_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        zp_r <= cfg_wr_data;
      end
      if (ctl.acc) begin
        pos_r <= pos_inc;
      end
      if (ctl.acc) begin
        v1_r <= 1'b1;
      end else if (ctl.ld2) begin
        v1_r <= 1'b0;
      end
      if (ctl.ld2) begin
        v2_r <= 1'b1;
      end else if (ctl.ld3) begin
        v2_r <= 1'b0;
      end
      if (ctl.ld3) begin
        v3_r <= 1'b1;
      end else if (v3_r && rdy4) begin
        v3_r <= 1'b0;
      end
    end
  end

  pcma_lane #(.WINDOW(WINDOW), .SMP_W(SMP_AC_W), .AVG_W(AVG_AC_W)) u_lane_a (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .pos(pos_r), .pos_inc(pos_inc),
    .smp(cur_a), .avg(avg_a)
  );

  pcma_lane #(.WINDOW(WINDOW), .SMP_W(SMP_B_W), .AVG_W(AVG_B_W)) u_lane_b (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .pos(pos_r), .pos_inc(pos_inc),
    .smp(cur_b), .avg(avg_b)
  );

  pcma_lane #(.WINDOW(WINDOW), .SMP_W(SMP_AC_W), .AVG_W(AVG_AC_W)) u_lane_c (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .pos(pos_r), .pos_inc(pos_inc),
    .smp(cur_c), .avg(avg_c)
  );

  pcma_merge u_merge (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .rdy(rdy4),
    .avg_a(avg_a), .avg_b(avg_b), .avg_c(avg_c),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW - 1))
    else $error("window position out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (!(ctl.acc && v1_r) || ctl.ld2) && (!(ctl.ld2 && v2_r) || ctl.ld3) &&
    (!(ctl.ld3 && v3_r) || rdy4))
    else $error("pipeline stage overwritten before it moved on");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r && out_tvalid)
    else $error("input stalled with room in the pipeline");

  a_beat_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc && !v1_r && !v2_r && !v3_r && !out_tvalid |-> ##3 v3_r)
    else $error("beat lost between accept and output stage");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  import pcma_pkg::*;

  localparam int WIN         = WINDOW_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 12;   // extra wait after the queues empty, for the pipeline to drain

  typedef struct packed {
    logic signed [AVG_AC_W-1:0] a;
    logic signed [AVG_B_W-1:0]  b;
    logic signed [AVG_AC_W-1:0] c;
  } avg_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_wr_en   = 1'b0;
  logic [ADC_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;   // [11:0] phase A code, [23:12] phase C code
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [16:0] avg A, [34:17] avg B, [51:35] avg C

  phase_current_moving_average uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // sample pairs waiting to be sent, averages waiting to come out
  logic [IN_TDATA_W-1:0] pair_q[$];
  avg_beat_t             avg_q[$];

  // local copy of the filter state
  logic [ADC_W-1:0]          zero_pt = ZERO_POINT_RST;
  logic signed [SMP_AC_W-1:0] win_a [WIN];
  logic signed [SMP_B_W-1:0]  win_b [WIN];
  logic signed [SMP_AC_W-1:0] win_c [WIN];
  int wr_pos;
  int sum_a, sum_b, sum_c;

  int  err_cnt   = 0;
  int  cycle_cnt = 0;
  bit  idle_on   = 1'b1;
  bit  beat_sent = 1'b0;
  int  send_gap  = 0;
  int  ready_gap = 0;

  task automatic flag_error(input string msg);
    if (err_cnt < 100) $display("mismatch @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // sum * 16 / WIN, nearest, ties away from zero
  function automatic int round_avg(input int total);
    int mag, q;
    mag = (total < 0) ? -total : total;
    q = ((mag << RND_SH) + WIN) / (2 * WIN);
    return (total < 0) ? -q : q;
  endfunction

  task automatic take_sample(input logic [ADC_W-1:0] smp_a, input logic [ADC_W-1:0] smp_c);
    int cur_a, cur_b, cur_c;
    avg_beat_t want;
    cur_a = int'(smp_a) - int'(zero_pt);
    cur_c = int'(smp_c) - int'(zero_pt);
    cur_b = -(cur_a + cur_c);
    sum_a += cur_a - int'(win_a[wr_pos]);
    sum_b += cur_b - int'(win_b[wr_pos]);
    sum_c += cur_c - int'(win_c[wr_pos]);
    win_a[wr_pos] = SMP_AC_W'(cur_a);
    win_b[wr_pos] = SMP_B_W'(cur_b);
    win_c[wr_pos] = SMP_AC_W'(cur_c);
    wr_pos = (wr_pos == WIN - 1) ? 0 : wr_pos + 1;
    want.a = AVG_AC_W'(round_avg(sum_a));
    want.b = AVG_B_W'(round_avg(sum_b));
    want.c = AVG_AC_W'(round_avg(sum_c));
    avg_q.push_back(want);
  endtask

  function automatic logic [ADC_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return ADC_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count);
    int left, run, kind;
    logic [ADC_W-1:0] va, vc;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 3);
      run  = $urandom_range(15, 40);
      if (run > left) run = left;
      va = pick_code();
      vc = pick_code();
      for (int i = 0; i < run; i++) begin
        case (kind)
          0: begin
            va = ADC_W'($urandom);
            vc = ADC_W'($urandom);
          end
          1: ;  // steady level, window fills with one value
          2: begin
            va = va + ADC_W'(97);
            vc = vc - ADC_W'(53);
          end
          default: begin
            va = $urandom_range(0, 1) ? '1 : '0;
            vc = $urandom_range(0, 1) ? '1 : '0;
          end
        endcase
        pair_q.push_back({vc, va});
      end
      left -= run;
    end
  endtask

  task automatic wait_idle();
    while (pair_q.size() != 0 || in_tvalid || avg_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_zero_point(input logic [ADC_W-1:0] zp);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= zp;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    zero_pt = zp;
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) begin
      win_a[i] = '0;
      win_b[i] = '0;
      win_c[i] = '0;
    end
    wr_pos = 0;
    sum_a  = 0;
    sum_b  = 0;
    sum_c  = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset zero point: corner codes, then a steady run through the wrap
    pair_q.push_back({12'd0,    12'd0});
    pair_q.push_back({12'd4095, 12'd4095});
    pair_q.push_back({12'd4095, 12'd0});
    pair_q.push_back({12'd0,    12'd4095});
    pair_q.push_back({12'd2055, 12'd2055});
    pair_q.push_back({12'd2056, 12'd2054});
    pair_q.push_back({12'd2047, 12'd2048});
    pair_q.push_back({12'hAAA,  12'h555});
    for (int i = 0; i < 16; i++) pair_q.push_back({12'd4095, 12'd4095});
    queue_random(100);
    wait_idle();

    set_zero_point(12'd0);
    for (int i = 0; i < 16; i++) pair_q.push_back({12'd4095, 12'd4095});
    queue_random(140);
    wait_idle();

    set_zero_point(12'd4095);
    for (int i = 0; i < 16; i++) pair_q.push_back({12'd0, 12'd0});
    queue_random(140);
    wait_idle();

    set_zero_point(ADC_W'($urandom));
    queue_random(150);
    wait_idle();

    // last stretch runs flat out
    idle_on = 1'b0;
    set_zero_point(12'd2048);
    queue_random(150);
    wait_idle();

    if (avg_q.size() != 0) flag_error("averages still outstanding at end");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input side
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      take_sample(in_tdata[ADC_W-1:0], in_tdata[2*ADC_W-1:ADC_W]);
      beat_sent = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || beat_sent)) begin
      beat_sent = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pair_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 9) - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= pair_q.pop_front();
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (ready_gap > 0) begin
      ready_gap--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_gap = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : avg_check
    avg_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (avg_q.size() == 0) begin
        flag_error("average beat with nothing outstanding");
      end else begin
        want = avg_q.pop_front();
        if (out_tdata[16:0] !== want.a)
          flag_error($sformatf("avg_a got %0d want %0d",
                               $signed(out_tdata[16:0]), want.a));
        if (out_tdata[34:17] !== want.b)
          flag_error($sformatf("avg_b got %0d want %0d",
                               $signed(out_tdata[34:17]), want.b));
        if (out_tdata[51:35] !== want.c)
          flag_error($sformatf("avg_c got %0d want %0d",
                               $signed(out_tdata[51:35]), want.c));
      end
    end
  end

endmodule
